[hdl/usrd_pkg.sv]
// ----------------------------------------------------------------------------
// usrd_pkg
// Types, request codes and reply codes shared by the standard request decoder.
// ----------------------------------------------------------------------------
package usrd_pkg;

  // string descriptors the block can serve at most
  localparam int MAX_STRINGS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_DESC_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_TOTAL_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LEN_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LEN_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LEN_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LEN_THREE = 3'd6;

  // register reset values
  localparam logic [7:0]  DEVICE_DESC_LEN_RST  = 8'd18;
  localparam logic [15:0] CONFIG_TOTAL_LEN_RST = 16'd9;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] REQ_SYNCH_FRAME       = 8'd12;

  // descriptor types (high byte of wValue)
  localparam logic [7:0] DESC_DEVICE        = 8'd1;
  localparam logic [7:0] DESC_CONFIGURATION = 8'd2;
  localparam logic [7:0] DESC_STRING        = 8'd3;

  localparam logic [15:0] FEATURE_ENDPOINT_HALT = 16'h0000;

  // recipient field of bmRequestType
  localparam logic [4:0] RECIPIENT_DEVICE   = 5'd0;
  localparam logic [4:0] RECIPIENT_ENDPOINT = 5'd2;

  localparam logic [15:0] STATUS_SELF_POWERED = 16'h0001;
  localparam logic [15:0] STATUS_HALTED       = 16'h0001;
  localparam logic [15:0] STATUS_CLEAR        = 16'h0000;

  localparam logic [15:0] INLINE_LEN_ONE = 16'd1;
  localparam logic [15:0] INLINE_LEN_TWO = 16'd2;

  // reply kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_ZLP    = 3'd1;
  localparam logic [2:0] KIND_DEVICE = 3'd2;
  localparam logic [2:0] KIND_CONFIG = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;
  localparam logic [2:0] KIND_INLINE = 3'd5;

  // halt bit changes
  localparam logic [1:0] HALT_NONE  = 2'd0;
  localparam logic [1:0] HALT_SET   = 2'd1;
  localparam logic [1:0] HALT_CLEAR = 2'd2;

  // one setup word
  typedef struct packed {
    logic [7:0]  setup_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [7:0]  current_configuration;
  } req_t;

  // one reply word
  typedef struct packed {
    logic        bad_setup;
    logic [2:0]  reply_kind;
    logic [15:0] reply_length;
    logic [15:0] reply_data;
    logic [1:0]  string_select;
    logic [1:0]  halt_change;
    logic [3:0]  halt_endpoint;
    logic        address_pending;
    logic [6:0]  new_address;
    logic        config_pending;
    logic [7:0]  new_configuration;
  } rsp_t;

  // descriptor settings
  typedef struct packed {
    logic [7:0]       device_desc_len;
    logic [15:0]      config_total_len;
    logic [2:0]       string_count;
    logic [3:0][7:0]  string_len;
  } cfg_t;

  // pending address and configuration
  typedef struct packed {
    logic       addr_mark;
    logic [6:0] addr;
    logic       conf_mark;
    logic [7:0] conf;
  } pend_t;

  // smaller of requested and available length
  function automatic logic [15:0] clip16(logic [15:0] want, logic [15:0] have);
    clip16 = (want < have) ? want : have;
  endfunction

endpackage

[hdl/usrd_cfg.sv]
// ----------------------------------------------------------------------------
// usrd_cfg
// Descriptor length and string count registers behind the write port.
// ----------------------------------------------------------------------------
module usrd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [usrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [usrd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output usrd_pkg::cfg_t                    cfg
);

  usrd_pkg::cfg_t cfg_r;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_desc_len  <= usrd_pkg::DEVICE_DESC_LEN_RST;
      cfg_r.config_total_len <= usrd_pkg::CONFIG_TOTAL_LEN_RST;
      cfg_r.string_count     <= '0;
      cfg_r.string_len       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usrd_pkg::CFG_DEVICE_DESC_LEN:  cfg_r.device_desc_len  <= cfg_wdata[7:0];
        usrd_pkg::CFG_CONFIG_TOTAL_LEN: cfg_r.config_total_len <= cfg_wdata[15:0];
        usrd_pkg::CFG_STRING_COUNT:     cfg_r.string_count     <= cfg_wdata[2:0];
        usrd_pkg::CFG_STRING_LEN_ZERO:  cfg_r.string_len[0]    <= cfg_wdata[7:0];
        usrd_pkg::CFG_STRING_LEN_ONE:   cfg_r.string_len[1]    <= cfg_wdata[7:0];
        usrd_pkg::CFG_STRING_LEN_TWO:   cfg_r.string_len[2]    <= cfg_wdata[7:0];
        usrd_pkg::CFG_STRING_LEN_THREE: cfg_r.string_len[3]    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/usrd_decode.sv]
// ----------------------------------------------------------------------------
// usrd_decode
// Decodes one setup word into the endpoint-0 reply and the next state.
// ----------------------------------------------------------------------------
module usrd_decode #(
  parameter int NUM_ENDPOINTS = 12
) (
  input  usrd_pkg::req_t             req,
  input  usrd_pkg::cfg_t             cfg,
  input  logic [NUM_ENDPOINTS-1:0]   halted,
  input  usrd_pkg::pend_t            pend,
  output usrd_pkg::rsp_t             rsp,
  output logic [NUM_ENDPOINTS-1:0]   halted_nxt,
  output usrd_pkg::pend_t            pend_nxt
);

  logic [3:0]  ep;
  logic        ep_ok;
  logic [15:0] halt_wide;
  logic [15:0] ep_mask_wide;
  logic [NUM_ENDPOINTS-1:0] ep_mask;
  logic [2:0]  str_n;
  logic        str_ok;
  logic [7:0]  str_len;

  // endpoint lookup
  assign ep           = req.request_index[3:0];
  assign ep_ok        = {1'b0, ep} < 5'(NUM_ENDPOINTS);
  assign halt_wide    = 16'(halted);
  assign ep_mask_wide = 16'd1 << ep;
  assign ep_mask      = ep_mask_wide[NUM_ENDPOINTS-1:0];

  // string index check against the saturated count
  assign str_n   = (cfg.string_count > 3'(usrd_pkg::MAX_STRINGS)) ?
                   3'(usrd_pkg::MAX_STRINGS) : cfg.string_count;
  assign str_ok  = req.request_value[7:0] < {5'd0, str_n};
  assign str_len = cfg.string_len[req.request_value[1:0]];

  // request decode
  always_comb begin
    rsp                   = '0;
    halted_nxt            = halted;
    pend_nxt              = pend;
    rsp.bad_setup         = 1'b0;
    rsp.reply_kind        = usrd_pkg::KIND_NONE;
    rsp.halt_change       = usrd_pkg::HALT_NONE;
    unique case (req.request_code) inside
      usrd_pkg::REQ_GET_DESCRIPTOR: begin
        unique case (req.request_value[15:8])
          usrd_pkg::DESC_DEVICE: begin
            rsp.reply_kind   = usrd_pkg::KIND_DEVICE;
            rsp.reply_length = usrd_pkg::clip16(req.request_length,
                                                {8'd0, cfg.device_desc_len});
          end
          usrd_pkg::DESC_CONFIGURATION: begin
            rsp.reply_kind   = usrd_pkg::KIND_CONFIG;
            rsp.reply_length = usrd_pkg::clip16(req.request_length,
                                                cfg.config_total_len);
          end
          usrd_pkg::DESC_STRING: begin
            if (str_ok) begin
              rsp.reply_kind    = usrd_pkg::KIND_STRING;
              rsp.string_select = req.request_value[1:0];
              rsp.reply_length  = usrd_pkg::clip16(req.request_length,
                                                   {8'd0, str_len});
            end else begin
              rsp.bad_setup = 1'b1;
            end
          end
          default: rsp.bad_setup = 1'b1;
        endcase
      end
      usrd_pkg::REQ_SET_ADDRESS: begin
        pend_nxt.addr      = req.request_value[6:0];
        pend_nxt.addr_mark = 1'b1;
        rsp.reply_kind     = usrd_pkg::KIND_ZLP;
      end
      usrd_pkg::REQ_SET_CONFIGURATION: begin
        pend_nxt.conf      = req.request_value[7:0];
        pend_nxt.conf_mark = 1'b1;
        rsp.reply_kind     = usrd_pkg::KIND_ZLP;
      end
      usrd_pkg::REQ_GET_CONFIGURATION: begin
        rsp.reply_kind   = usrd_pkg::KIND_INLINE;
        rsp.reply_length = usrd_pkg::INLINE_LEN_ONE;
        rsp.reply_data   = {8'd0, req.current_configuration};
      end
      usrd_pkg::REQ_SET_FEATURE, usrd_pkg::REQ_CLEAR_FEATURE: begin
        if (req.request_value == usrd_pkg::FEATURE_ENDPOINT_HALT) begin
          rsp.reply_kind = usrd_pkg::KIND_ZLP;
          if (ep_ok) begin
            rsp.halt_endpoint = ep;
            if (req.request_code == usrd_pkg::REQ_SET_FEATURE) begin
              halted_nxt      = halted | ep_mask;
              rsp.halt_change = usrd_pkg::HALT_SET;
            end else begin
              halted_nxt      = halted & ~ep_mask;
              rsp.halt_change = usrd_pkg::HALT_CLEAR;
            end
          end
        end else begin
          rsp.bad_setup = 1'b1;
        end
      end
      usrd_pkg::REQ_GET_STATUS: begin
        rsp.reply_kind   = usrd_pkg::KIND_INLINE;
        rsp.reply_length = usrd_pkg::INLINE_LEN_TWO;
        if (req.setup_type[4:0] == usrd_pkg::RECIPIENT_DEVICE) begin
          rsp.reply_data = usrd_pkg::STATUS_SELF_POWERED;
        end else if (req.setup_type[4:0] == usrd_pkg::RECIPIENT_ENDPOINT) begin
          rsp.reply_data = (ep_ok && halt_wide[ep]) ?
                           usrd_pkg::STATUS_HALTED : usrd_pkg::STATUS_CLEAR;
        end
      end
      usrd_pkg::REQ_SET_INTERFACE: begin
        rsp.reply_kind = usrd_pkg::KIND_ZLP;
      end
      usrd_pkg::REQ_GET_INTERFACE: begin
        rsp.reply_kind   = usrd_pkg::KIND_INLINE;
        rsp.reply_length = usrd_pkg::INLINE_LEN_ONE;
      end
      usrd_pkg::REQ_SYNCH_FRAME: begin
        rsp.reply_kind   = usrd_pkg::KIND_INLINE;
        rsp.reply_length = usrd_pkg::INLINE_LEN_TWO;
      end
      default: rsp.bad_setup = 1'b1;
    endcase
    // state after this request
    rsp.address_pending   = pend_nxt.addr_mark;
    rsp.new_address       = pend_nxt.addr;
    rsp.config_pending    = pend_nxt.conf_mark;
    rsp.new_configuration = pend_nxt.conf;
  end

endmodule

[hdl/usb_standard_request_decoder_top.sv]
// ----------------------------------------------------------------------------
// usb_standard_request_decoder_top: endpoint-0 standard request decoder
// Stages: input register, decode, reply register to out_.
// Throughput: one word per cycle unless out_stall holds the reply register.
// Reset: synchronous; clears valids, halt bits and pending state, resets the settings.
// ----------------------------------------------------------------------------
module usb_standard_request_decoder_top #(
  parameter int NUM_ENDPOINTS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  usrd_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output usrd_pkg::rsp_t                    out_data,
  input  logic                              cfg_we,
  input  logic [usrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [usrd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic                       s1_vld_r;
  usrd_pkg::req_t             s1_data_r;
  logic                       out_vld_r;
  usrd_pkg::rsp_t             out_data_r;
  logic [NUM_ENDPOINTS-1:0]   halted_r;
  logic [NUM_ENDPOINTS-1:0]   halted_nxt;
  usrd_pkg::pend_t            pend_r;
  usrd_pkg::pend_t            pend_nxt;
  usrd_pkg::rsp_t             rsp_nxt;
  usrd_pkg::cfg_t             cfg;
  logic                       s1_adv;
  logic                       s1_load;
  logic                       commit;

  // handshake
  assign s1_adv   = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !s1_adv;
  assign s1_load  = in_valid && !in_stall;
  assign commit   = s1_vld_r && s1_adv;

  usrd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  usrd_decode #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS)
  ) u_decode (
    .req        (s1_data_r),
    .cfg        (cfg),
    .halted     (halted_r),
    .pend       (pend_r),
    .rsp        (rsp_nxt),
    .halted_nxt (halted_nxt),
    .pend_nxt   (pend_nxt)
  );

  // valids and request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      halted_r  <= '0;
      pend_r    <= '0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (commit) begin
        halted_r <= halted_nxt;
        pend_r   <= pend_nxt;
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
  end

  // reply word register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // halt bits only move when a decoded word is committed
  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(halted_r))
    else $error("halt bits changed without a committed word");

  // a pending address mark stays set until reset
  a_addr_mark: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r.addr_mark |=> pend_r.addr_mark)
    else $error("address pending mark dropped");

  // a committed word shows up on the output next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid)
    else $error("committed word not presented");

  // a set halt leaves at least one halt bit high
  a_halt_set: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (rsp_nxt.halt_change == usrd_pkg::HALT_SET) |=> (halted_r != '0))
    else $error("set halt left no halt bit");

  // input stalls only while the input register holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");
`endif

endmodule

[test/usrd_reply_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usrd_reply_checker: reply predictor and scoreboard for the request decoder
// Watches the setup, reply and register ports, keeps its own copy of the
// descriptor settings, halt bits and pending values, and compares each
// accepted reply word field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module usrd_reply_checker #(
  parameter int NUM_ENDPOINTS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  usrd_pkg::req_t                  in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  usrd_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [usrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              words_due
);

  // predictor state
  usrd_pkg::cfg_t  settings;
  logic [15:0]     halted;
  usrd_pkg::pend_t pending;

  usrd_pkg::rsp_t replies_due[$];
  int   mismatches = 0;
  int   due_count  = 0;
  int   reply_no   = 0;

  assign fail_count = mismatches;
  assign words_due  = due_count;

  // one line per failure, and count it
  task automatic flag_error(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("reply %0d %s got %0h want %0h", reply_no, name, got, want));
    end
  endtask

  function automatic logic [15:0] shorter(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  task automatic clear_state();
    settings                  = '0;
    settings.device_desc_len  = usrd_pkg::DEVICE_DESC_LEN_RST;
    settings.config_total_len = usrd_pkg::CONFIG_TOTAL_LEN_RST;
    halted                    = '0;
    pending                   = '0;
  endtask

  task automatic apply_setting(input logic [usrd_pkg::CFG_IDX_W-1:0] idx,
                               input logic [usrd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      usrd_pkg::CFG_DEVICE_DESC_LEN:  settings.device_desc_len  = val[7:0];
      usrd_pkg::CFG_CONFIG_TOTAL_LEN: settings.config_total_len = val[15:0];
      usrd_pkg::CFG_STRING_COUNT:     settings.string_count     = val[2:0];
      usrd_pkg::CFG_STRING_LEN_ZERO:  settings.string_len[0]    = val[7:0];
      usrd_pkg::CFG_STRING_LEN_ONE:   settings.string_len[1]    = val[7:0];
      usrd_pkg::CFG_STRING_LEN_TWO:   settings.string_len[2]    = val[7:0];
      usrd_pkg::CFG_STRING_LEN_THREE: settings.string_len[3]    = val[7:0];
      default: ;
    endcase
  endtask

  // decode one setup word and update halt bits and pending values
  function automatic usrd_pkg::rsp_t predict_reply(input usrd_pkg::req_t w);
    usrd_pkg::rsp_t r;
    logic [3:0]     ep;
    logic           ep_ok;
    logic [7:0]     idx;
    logic [2:0]     n_str;
    r     = '0;
    ep    = w.request_index[3:0];
    ep_ok = (ep < NUM_ENDPOINTS);
    case (w.request_code) inside
      usrd_pkg::REQ_GET_DESCRIPTOR: begin
        case (w.request_value[15:8])
          usrd_pkg::DESC_DEVICE: begin
            r.reply_kind   = usrd_pkg::KIND_DEVICE;
            r.reply_length = shorter(w.request_length,
                                     {8'h00, settings.device_desc_len});
          end
          usrd_pkg::DESC_CONFIGURATION: begin
            r.reply_kind   = usrd_pkg::KIND_CONFIG;
            r.reply_length = shorter(w.request_length, settings.config_total_len);
          end
          usrd_pkg::DESC_STRING: begin
            idx   = w.request_value[7:0];
            // counts above the table size saturate
            n_str = (settings.string_count > usrd_pkg::MAX_STRINGS) ?
                    3'(usrd_pkg::MAX_STRINGS) : settings.string_count;
            if (idx < n_str) begin
              r.reply_kind    = usrd_pkg::KIND_STRING;
              r.string_select = idx[1:0];
              r.reply_length  = shorter(w.request_length,
                                        {8'h00, settings.string_len[idx[1:0]]});
            end else begin
              r.bad_setup = 1'b1;
            end
          end
          default: r.bad_setup = 1'b1;
        endcase
      end
      usrd_pkg::REQ_SET_ADDRESS: begin
        pending.addr      = w.request_value[6:0];
        pending.addr_mark = 1'b1;
        r.reply_kind      = usrd_pkg::KIND_ZLP;
      end
      usrd_pkg::REQ_SET_CONFIGURATION: begin
        pending.conf      = w.request_value[7:0];
        pending.conf_mark = 1'b1;
        r.reply_kind      = usrd_pkg::KIND_ZLP;
      end
      usrd_pkg::REQ_GET_CONFIGURATION: begin
        r.reply_kind   = usrd_pkg::KIND_INLINE;
        r.reply_length = usrd_pkg::INLINE_LEN_ONE;
        r.reply_data   = {8'h00, w.current_configuration};
      end
      usrd_pkg::REQ_SET_FEATURE, usrd_pkg::REQ_CLEAR_FEATURE: begin
        // only endpoint halt, recipient not checked
        if (w.request_value == usrd_pkg::FEATURE_ENDPOINT_HALT) begin
          r.reply_kind = usrd_pkg::KIND_ZLP;
          if (ep_ok) begin
            r.halt_endpoint = ep;
            if (w.request_code == usrd_pkg::REQ_SET_FEATURE) begin
              halted[ep]    = 1'b1;
              r.halt_change = usrd_pkg::HALT_SET;
            end else begin
              halted[ep]    = 1'b0;
              r.halt_change = usrd_pkg::HALT_CLEAR;
            end
          end
        end else begin
          r.bad_setup = 1'b1;
        end
      end
      usrd_pkg::REQ_GET_STATUS: begin
        r.reply_kind   = usrd_pkg::KIND_INLINE;
        r.reply_length = usrd_pkg::INLINE_LEN_TWO;
        if (w.setup_type[4:0] == usrd_pkg::RECIPIENT_DEVICE) begin
          r.reply_data = usrd_pkg::STATUS_SELF_POWERED;
        end else if (w.setup_type[4:0] == usrd_pkg::RECIPIENT_ENDPOINT) begin
          r.reply_data = (ep_ok && halted[ep]) ? usrd_pkg::STATUS_HALTED
                                               : usrd_pkg::STATUS_CLEAR;
        end
      end
      usrd_pkg::REQ_SET_INTERFACE: r.reply_kind = usrd_pkg::KIND_ZLP;
      usrd_pkg::REQ_GET_INTERFACE: begin
        r.reply_kind   = usrd_pkg::KIND_INLINE;
        r.reply_length = usrd_pkg::INLINE_LEN_ONE;
      end
      usrd_pkg::REQ_SYNCH_FRAME: begin
        r.reply_kind   = usrd_pkg::KIND_INLINE;
        r.reply_length = usrd_pkg::INLINE_LEN_TWO;
      end
      default: r.bad_setup = 1'b1;
    endcase
    r.address_pending   = pending.addr_mark;
    r.new_address       = pending.addr;
    r.config_pending    = pending.conf_mark;
    r.new_configuration = pending.conf;
    return r;
  endfunction

  task automatic compare_reply(input usrd_pkg::rsp_t got);
    usrd_pkg::rsp_t want;
    reply_no++;
    if (replies_due.size() == 0) begin
      flag_error($sformatf("reply %0d arrived with none outstanding", reply_no));
      return;
    end
    want = replies_due.pop_front();
    check_field("bad_setup", got.bad_setup, want.bad_setup);
    check_field("reply_kind", got.reply_kind, want.reply_kind);
    check_field("reply_length", got.reply_length, want.reply_length);
    check_field("reply_data", got.reply_data, want.reply_data);
    check_field("string_select", got.string_select, want.string_select);
    check_field("halt_change", got.halt_change, want.halt_change);
    check_field("halt_endpoint", got.halt_endpoint, want.halt_endpoint);
    check_field("address_pending", got.address_pending, want.address_pending);
    check_field("new_address", got.new_address, want.new_address);
    check_field("config_pending", got.config_pending, want.config_pending);
    check_field("new_configuration", got.new_configuration, want.new_configuration);
  endtask

  // sample between edges: values here are the ones seen at the next rising edge
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_state();
      replies_due.delete();
    end else begin
      if (cfg_we) apply_setting(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) compare_reply(out_data);
      if (in_valid && !in_stall) replies_due.push_back(predict_reply(in_data));
    end
    due_count = replies_due.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the endpoint-0 standard request decoder
// Sends a directed set of setup words, then random words over several
// descriptor settings and idle patterns, including a long reply hold-off.
// Checking is done by usrd_reply_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_EP        = 12;
  localparam int SEGMENTS      = 6;
  localparam int ITEMS_PER_SEG = 284;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_GAP     = 4;
  localparam int CYCLE_LIMIT   = 300000;

  // setup byte pieces not in the package
  localparam logic [2:0]                     DIR_IN              = 3'b100;
  localparam logic [2:0]                     DIR_OUT             = 3'b000;
  localparam logic [4:0]                     RECIPIENT_INTERFACE = 5'd1;
  localparam logic [7:0]                     UNKNOWN_CODE        = 8'hFF;
  localparam logic [15:0]                    FEATURE_WAKEUP      = 16'h0001;
  localparam logic [usrd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX      = 3'd7;

  // short local names for package codes used in the directed words
  localparam logic [4:0]  RCP_DEV  = usrd_pkg::RECIPIENT_DEVICE;
  localparam logic [4:0]  RCP_EP   = usrd_pkg::RECIPIENT_ENDPOINT;
  localparam logic [15:0] EP_HALT  = usrd_pkg::FEATURE_ENDPOINT_HALT;
  localparam logic [7:0]  GET_DESC = usrd_pkg::REQ_GET_DESCRIPTOR;
  localparam logic [7:0]  GET_STAT = usrd_pkg::REQ_GET_STATUS;
  localparam logic [7:0]  SET_FEAT = usrd_pkg::REQ_SET_FEATURE;
  localparam logic [7:0]  CLR_FEAT = usrd_pkg::REQ_CLEAR_FEATURE;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  usrd_pkg::req_t                  in_data   = '0;
  logic                            out_stall = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [usrd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [usrd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_stall;
  logic                            out_valid;
  usrd_pkg::rsp_t                  out_data;
  int                              fail_count;
  int                              words_due;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int cycle_count   = 0;

  usb_standard_request_decoder_top #(
    .NUM_ENDPOINTS(NUM_EP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  usrd_reply_checker #(
    .NUM_ENDPOINTS(NUM_EP)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // reply side: random stall, or a long hold-off when one is requested
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic usrd_pkg::req_t setup_word(input logic [7:0] rtype,
                                                input logic [7:0] code,
                                                input logic [15:0] value,
                                                input logic [15:0] index,
                                                input logic [15:0] length,
                                                input logic [7:0] curcfg);
    usrd_pkg::req_t w;
    w.setup_type            = rtype;
    w.request_code          = code;
    w.request_value         = value;
    w.request_index         = index;
    w.request_length        = length;
    w.current_configuration = curcfg;
    return w;
  endfunction

  // mostly standard requests with random content, some noise
  function automatic usrd_pkg::req_t random_setup();
    usrd_pkg::req_t w;
    logic [7:0]     std_codes [10];
    std_codes = '{usrd_pkg::REQ_GET_STATUS, usrd_pkg::REQ_CLEAR_FEATURE,
                  usrd_pkg::REQ_SET_FEATURE, usrd_pkg::REQ_SET_ADDRESS,
                  usrd_pkg::REQ_GET_DESCRIPTOR, usrd_pkg::REQ_GET_CONFIGURATION,
                  usrd_pkg::REQ_SET_CONFIGURATION, usrd_pkg::REQ_GET_INTERFACE,
                  usrd_pkg::REQ_SET_INTERFACE, usrd_pkg::REQ_SYNCH_FRAME};
    w.setup_type            = 8'($urandom);
    w.request_code          = 8'($urandom);
    w.request_value         = 16'($urandom);
    w.request_index         = 16'($urandom);
    w.current_configuration = 8'($urandom);
    if ($urandom_range(99) < 85) w.request_code = std_codes[$urandom_range(9)];
    if ($urandom_range(3) != 0) begin
      w.setup_type[4:0] = $urandom_range(1) ? RCP_EP : RCP_DEV;
    end
    case ($urandom_range(3))
      0: w.request_length = 16'($urandom);
      1: w.request_length = 16'($urandom_range(300));
      2: w.request_length = 16'($urandom_range(20));
      default: w.request_length = 16'hFFFF;
    endcase
    case (w.request_code) inside
      usrd_pkg::REQ_GET_DESCRIPTOR: begin
        if ($urandom_range(9) != 0) begin
          case ($urandom_range(2))
            0: w.request_value[15:8] = usrd_pkg::DESC_DEVICE;
            1: w.request_value[15:8] = usrd_pkg::DESC_CONFIGURATION;
            default: w.request_value[15:8] = usrd_pkg::DESC_STRING;
          endcase
        end
        if (w.request_value[15:8] == usrd_pkg::DESC_STRING && $urandom_range(3) != 0) begin
          w.request_value[7:0] = 8'($urandom_range(5));
        end
      end
      usrd_pkg::REQ_SET_FEATURE, usrd_pkg::REQ_CLEAR_FEATURE: begin
        if ($urandom_range(4) != 0) w.request_value = EP_HALT;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic usrd_pkg::cfg_t random_settings(input bit over_count);
    usrd_pkg::cfg_t s;
    s.device_desc_len  = 8'($urandom);
    s.config_total_len = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(300));
    s.string_count     = over_count ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    for (int i = 0; i < usrd_pkg::MAX_STRINGS; i++) s.string_len[i] = 8'($urandom);
    return s;
  endfunction

  // offer one setup word and hold it until taken
  task automatic push_word(input usrd_pkg::req_t w);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic put_reg(input logic [usrd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [usrd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all registers, with junk above each narrow field
  task automatic load_settings(input usrd_pkg::cfg_t s);
    put_reg(usrd_pkg::CFG_DEVICE_DESC_LEN, {8'($urandom), s.device_desc_len});
    put_reg(usrd_pkg::CFG_CONFIG_TOTAL_LEN, s.config_total_len);
    put_reg(usrd_pkg::CFG_STRING_COUNT, {13'($urandom), s.string_count});
    for (int i = 0; i < usrd_pkg::MAX_STRINGS; i++) begin
      put_reg(usrd_pkg::CFG_STRING_LEN_ZERO + usrd_pkg::CFG_IDX_W'(i),
              {8'($urandom), s.string_len[i]});
    end
    put_reg(CFG_UNUSED_IDX, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    usrd_pkg::cfg_t top_end;
    top_end              = '1;
    top_end.string_count = 3'(usrd_pkg::MAX_STRINGS);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_STAT, 16'h0000, 16'h0000,
                         16'hFFFF, 8'h00));
    push_word(setup_word({DIR_IN, RCP_EP}, GET_STAT, 16'h0000, 16'h0081,
                         16'h0002, 8'h00));
    push_word(setup_word({DIR_OUT, RCP_EP}, SET_FEAT, EP_HALT, 16'h0081,
                         16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_EP}, GET_STAT, 16'h0000, 16'h0081,
                         16'h0002, 8'h00));
    push_word(setup_word({DIR_OUT, RCP_EP}, SET_FEAT, EP_HALT, 16'h000B,
                         16'h0000, 8'h00));
    // endpoint beyond the count
    push_word(setup_word({DIR_OUT, RCP_EP}, SET_FEAT, EP_HALT, 16'hFFFF,
                         16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_EP}, GET_STAT, 16'h0000, 16'hFFFF,
                         16'h0002, 8'h00));
    push_word(setup_word({DIR_OUT, RCP_EP}, CLR_FEAT, EP_HALT, 16'h0081,
                         16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_EP}, GET_STAT, 16'h0000, 16'h0081,
                         16'h0002, 8'h00));
    // unsupported features and recipient
    push_word(setup_word({DIR_OUT, RCP_DEV}, SET_FEAT, FEATURE_WAKEUP,
                         16'h0000, 16'h0000, 8'h00));
    push_word(setup_word({DIR_OUT, RCP_EP}, CLR_FEAT, 16'hFFFF,
                         16'h0001, 16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RECIPIENT_INTERFACE}, GET_STAT, 16'h0000, 16'h0000,
                         16'h0002, 8'h00));
    // descriptors, clipped and unclipped, and bad ones
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_DESC,
                         {usrd_pkg::DESC_DEVICE, 8'h00}, 16'h0000, 16'hFFFF, 8'h00));
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_DESC,
                         {usrd_pkg::DESC_DEVICE, 8'h00}, 16'h0000, 16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_DESC,
                         {usrd_pkg::DESC_CONFIGURATION, 8'h00}, 16'h0000, 16'h0004,
                         8'h00));
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_DESC,
                         {usrd_pkg::DESC_STRING, 8'h00}, 16'h0409, 16'h00FF, 8'h00));
    push_word(setup_word({DIR_IN, RCP_DEV}, GET_DESC, 16'hFFFF,
                         16'h0000, 16'h00FF, 8'h00));
    // pending address and configuration, then the other requests
    push_word(setup_word({DIR_OUT, RCP_DEV}, usrd_pkg::REQ_SET_ADDRESS, 16'hFFFF,
                         16'h0000, 16'h0000, 8'h00));
    push_word(setup_word({DIR_OUT, RCP_DEV}, usrd_pkg::REQ_SET_CONFIGURATION, 16'hFFFF,
                         16'h0000, 16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_DEV}, usrd_pkg::REQ_GET_CONFIGURATION, 16'h0000,
                         16'h0000, 16'h0001, 8'hFF));
    push_word(setup_word({DIR_IN, RECIPIENT_INTERFACE}, usrd_pkg::REQ_GET_INTERFACE,
                         16'h0000, 16'h0000, 16'h0001, 8'h00));
    push_word(setup_word({DIR_OUT, RECIPIENT_INTERFACE}, usrd_pkg::REQ_SET_INTERFACE,
                         16'h0001, 16'h0000, 16'h0000, 8'h00));
    push_word(setup_word({DIR_IN, RCP_EP}, usrd_pkg::REQ_SYNCH_FRAME, 16'h0000,
                         16'h0081, 16'h0002, 8'h00));
    push_word(setup_word(8'hFF, UNKNOWN_CODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));

    // random words over several settings and idle patterns
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_replies();
      case (seg)
        0: load_settings(top_end);
        1: load_settings('0);
        3: load_settings(random_settings(1'b1));
        default: load_settings(random_settings(1'b0));
      endcase
      send_idle_pct = (seg < 2) ? 15 : ((seg < 4) ? 56 : 0);
      recv_idle_pct = (seg < 2) ? 56 : ((seg < 4) ? 15 : 0);
      for (int k = 0; k < ITEMS_PER_SEG; k++) begin
        // long reply hold-off so the decoder backs up
        if ((seg == 0 || seg == SEGMENTS - 1) && k == 100) hold_requests++;
        push_word(random_setup());
      end
    end

    recv_idle_pct = 0;
    drain_replies();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
